/* rtl/rsa_pkg.sv */
// Shared types and constants for the ring staging allocator.
// Holds the command and result beat structs and the field widths.
// No dependencies; every other file imports this package.
package rsa_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int SIZE_W      = OFFSET_BITS + 1;
	localparam int ALIGN_W     = 17;
	localparam int WASTE_W     = 40;
	localparam int COUNT_W     = 32;

	localparam logic [SIZE_W-1:0]  REGION_CAP      = SIZE_W'(1) << OFFSET_BITS;
	localparam logic [COUNT_W-1:0] FRAG_WRAP_LIMIT = COUNT_W'(10);

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_RESET = 1'b1;

	typedef struct packed {
		logic               action;
		logic [SIZE_W-1:0]  request_size;
		logic [ALIGN_W-1:0] alignment;
	} cmd_beat_t;

	typedef struct packed {
		logic                   granted;
		logic [OFFSET_BITS-1:0] offset;
		logic [WASTE_W-1:0]     wasted_bytes;
		logic [COUNT_W-1:0]     wraps;
		logic [SIZE_W-1:0]      largest_free;
		logic [COUNT_W-1:0]     alloc_requests;
		logic [COUNT_W-1:0]     failed_requests;
		logic                   fragmentation_critical;
		logic                   under_pressure;
	} result_beat_t;

	typedef struct packed {
		logic frag;
		logic press;
	} health_t;

endpackage

/* rtl/rsa_rem_unit.sv */
// Iterative remainder unit: one restoring step per cycle, one dividend bit each.
// Computes dividend mod divisor for the align-up of the ring offset.
// Depends on rsa_pkg for the field widths.
module rsa_rem_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rsa_pkg::SIZE_W-1:0]  dividend,
	input  logic [rsa_pkg::ALIGN_W-1:0] divisor,
	output logic                       done,
	output logic [rsa_pkg::ALIGN_W-1:0] remainder
);
	import rsa_pkg::*;

	localparam int CNT_W = $clog2(SIZE_W);

	logic               active_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SIZE_W-1:0]  dvd_q;
	logic [ALIGN_W-1:0] dsr_q;
	logic [ALIGN_W-1:0] rem_q;
	logic [ALIGN_W:0]   trial;
	logic [ALIGN_W-1:0] rem_nxt;

	// The partial remainder stays below the divisor, so one extra bit holds the trial.
	always_comb begin
		trial = {rem_q, dvd_q[SIZE_W-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_nxt = ALIGN_W'(trial - {1'b0, dsr_q});
		end else begin
			rem_nxt = trial[ALIGN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(SIZE_W - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (active_q) begin
			dvd_q <= {dvd_q[SIZE_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

/* rtl/rsa_health.sv */
// Health flag logic: fragmentation and pressure from the running totals.
// The ratio tests are exact integer compares built from shifts and adds.
// Depends on rsa_pkg for widths and the health_t struct.
module rsa_health (
	input  logic [rsa_pkg::SIZE_W-1:0]  region,
	input  logic [rsa_pkg::WASTE_W-1:0] waste_total,
	input  logic [rsa_pkg::COUNT_W-1:0] wrap_total,
	input  logic [rsa_pkg::COUNT_W-1:0] request_total,
	input  logic [rsa_pkg::COUNT_W-1:0] failure_total,
	output rsa_pkg::health_t            health
);
	import rsa_pkg::*;

	logic [WASTE_W+3:0] waste_x10;
	logic [SIZE_W+1:0]  region_x3;
	logic [COUNT_W+3:0] fail_x10;
	logic               frag;

	always_comb begin
		waste_x10 = ({4'b0, waste_total} << 3) + ({4'b0, waste_total} << 1);
		region_x3 = ({2'b0, region} << 1) + {2'b0, region};
		fail_x10  = ({4'b0, failure_total} << 3) + ({4'b0, failure_total} << 1);
		frag = (region != '0) &&
		       ((waste_x10 > (WASTE_W+4)'(region_x3)) || (wrap_total > FRAG_WRAP_LIMIT));
		health.frag  = frag;
		health.press = (request_total != '0) &&
		               ((fail_x10 > (COUNT_W+4)'(request_total)) || frag);
	end

endmodule

/* rtl/ring_staging_allocator_unit.sv */
// Top level of the ring staging allocator: sequencer, allocator state and result register.
// Uses rsa_rem_unit for the align-up remainder and rsa_health for the flags.
// Depends on rsa_pkg.
//
// Usage:
//   A command beat on cmd is taken at a rising edge where start is high and busy
//   is low. busy stays high until the result beat has been produced.
//   Each command gives exactly one result beat on result, shown for one cycle with
//   done high. The receiver cannot stall; it must take the beat in that cycle.
//   cfg_we with cfg_data writes region_size (capped at 2^24); write it only while
//   busy is low.
// Sequencing:
//   An allocate that reaches the align step runs the remainder unit, one dividend
//   bit per cycle, until it reports done, then steps through ST_CALC, ST_UPD and
//   ST_FLAG before done rises. A reset action, or an allocate with zero size or
//   no region, skips the remainder unit and goes straight to ST_FLAG before done
//   rises. A new command can be taken in the cycle done is high; commands are
//   handled one at a time, and no new one is taken while busy is high.
// Reset:
//   arst_n clears region_size, the offset, all totals and the sequencer.
module ring_staging_allocator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  rsa_pkg::cmd_beat_t         cmd,
	output logic                       done,
	output rsa_pkg::result_beat_t      result,
	input  logic                       cfg_we,
	input  logic [rsa_pkg::SIZE_W-1:0] cfg_data
);
	import rsa_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_CALC = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_FLAG = 5'b10000
	} state_t;

	state_t             state_q;
	logic [SIZE_W-1:0]  region_q;
	logic [SIZE_W-1:0]  next_offset_q;
	logic [WASTE_W-1:0] waste_total_q;
	logic [COUNT_W-1:0] wrap_total_q;
	logic [SIZE_W-1:0]  free_tail_max_q;
	logic [COUNT_W-1:0] request_total_q;
	logic [COUNT_W-1:0] failure_total_q;

	logic [SIZE_W-1:0]  size_q;
	logic [ALIGN_W-1:0] align_q;
	logic [SIZE_W:0]    aligned_q;
	logic [ALIGN_W-1:0] pad_q;
	logic [SIZE_W+1:0]  end_q;
	logic               fits_q;
	logic               granted_q;
	logic [SIZE_W:0]    offset_q;
	logic               done_q;
	result_beat_t       result_q;

	logic               accept;
	logic               div_start;
	logic               div_done;
	logic [ALIGN_W-1:0] remainder;
	logic [ALIGN_W-1:0] align_eff;
	logic [ALIGN_W-1:0] pad;
	logic [SIZE_W:0]    aligned;
	logic [SIZE_W+1:0]  end_sum;
	logic [SIZE_W:0]    tail_waste;
	logic [SIZE_W:0]    waste_add;
	logic [SIZE_W+1:0]  end_upd;
	logic [SIZE_W:0]    start_upd;
	logic               ok_upd;
	logic [WASTE_W:0]   waste_sum;
	logic [SIZE_W+1:0]  tail;
	health_t            health;

	assign accept    = start && (state_q == ST_IDLE);
	assign align_eff = (cmd.alignment == '0) ? ALIGN_W'(1) : cmd.alignment;
	assign div_start = accept && (cmd.action == ACT_ALLOC) &&
	                   (region_q != '0) && (cmd.request_size != '0);

	rsa_rem_unit u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (next_offset_q),
		.divisor   (align_eff),
		.done      (div_done),
		.remainder (remainder)
	);

	rsa_health u_health (
		.region        (region_q),
		.waste_total   (waste_total_q),
		.wrap_total    (wrap_total_q),
		.request_total (request_total_q),
		.failure_total (failure_total_q),
		.health        (health)
	);

	// Align-up: add the distance from the remainder to the next multiple.
	always_comb begin
		pad     = (remainder == '0) ? '0 : ALIGN_W'(align_q - remainder);
		aligned = {1'b0, next_offset_q} + (SIZE_W+1)'(pad);
		end_sum = {1'b0, aligned} + (SIZE_W+2)'(size_q);
	end

	// On a wrap the skipped tail counts as waste, unless the region has shrunk
	// below the current offset.
	always_comb begin
		tail_waste = (region_q > next_offset_q) ? (SIZE_W+1)'(region_q - next_offset_q) : '0;
		if (fits_q) begin
			ok_upd    = 1'b1;
			start_upd = aligned_q;
			end_upd   = end_q;
			waste_add = (SIZE_W+1)'(pad_q);
		end else begin
			ok_upd    = (size_q <= region_q);
			start_upd = '0;
			end_upd   = (SIZE_W+2)'(size_q);
			waste_add = (SIZE_W+1)'(pad_q) + tail_waste;
		end
		waste_sum = {1'b0, waste_total_q} + (WASTE_W+1)'(waste_add);
		tail      = (SIZE_W+2)'(region_q) - end_upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			region_q        <= '0;
			next_offset_q   <= '0;
			waste_total_q   <= '0;
			wrap_total_q    <= '0;
			free_tail_max_q <= '0;
			request_total_q <= '0;
			failure_total_q <= '0;
			done_q          <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				region_q <= (cfg_data > REGION_CAP) ? REGION_CAP : cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.action == ACT_RESET) begin
							next_offset_q   <= '0;
							waste_total_q   <= '0;
							free_tail_max_q <= region_q;
							state_q         <= ST_FLAG;
						end else begin
							if (request_total_q != '1) begin
								request_total_q <= request_total_q + COUNT_W'(1);
							end
							if (div_start) begin
								state_q <= ST_DIV;
							end else begin
								if (failure_total_q != '1) begin
									failure_total_q <= failure_total_q + COUNT_W'(1);
								end
								state_q <= ST_FLAG;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (!fits_q && (wrap_total_q != '1)) begin
						wrap_total_q <= wrap_total_q + COUNT_W'(1);
					end
					if (ok_upd) begin
						waste_total_q <= waste_sum[WASTE_W] ? '1 : waste_sum[WASTE_W-1:0];
						if (SIZE_W'(tail) > free_tail_max_q) begin
							free_tail_max_q <= SIZE_W'(tail);
						end
						next_offset_q <= end_upd[SIZE_W-1:0];
					end else if (failure_total_q != '1) begin
						failure_total_q <= failure_total_q + COUNT_W'(1);
					end
					state_q <= ST_FLAG;
				end
				ST_FLAG: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers for the command in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			size_q    <= cmd.request_size;
			align_q   <= align_eff;
			granted_q <= (cmd.action == ACT_RESET);
			offset_q  <= '0;
		end
		if (state_q == ST_CALC) begin
			pad_q     <= pad;
			aligned_q <= aligned;
			end_q     <= end_sum;
			fits_q    <= (end_sum <= (SIZE_W+2)'(region_q));
		end
		if (state_q == ST_UPD) begin
			granted_q <= ok_upd;
			offset_q  <= ok_upd ? start_upd : '0;
		end
		if (state_q == ST_FLAG) begin
			result_q.granted                <= granted_q;
			result_q.offset                 <= offset_q[OFFSET_BITS-1:0];
			result_q.wasted_bytes           <= waste_total_q;
			result_q.wraps                  <= wrap_total_q;
			result_q.largest_free           <= free_tail_max_q;
			result_q.alloc_requests         <= request_total_q;
			result_q.failed_requests        <= failure_total_q;
			result_q.fragmentation_critical <= health.frag;
			result_q.under_pressure         <= health.press;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

/* tb/ring_staging_allocator_unit_tb.sv */
// Testbench for ring_staging_allocator_unit: directed and random allocate/reset commands.
// A scoreboard class predicts every result beat and compares each one field by field.
// Depends on rsa_pkg and the ring_staging_allocator_unit RTL.
module ring_staging_allocator_unit_tb;
	import rsa_pkg::*;

	localparam logic [63:0] WASTE_MAX = 64'hFF_FFFF_FFFF;
	localparam logic [63:0] COUNT_MAX = 64'hFFFF_FFFF;

	class alloc_scoreboard;
		bit [SIZE_W-1:0]  region;
		bit [SIZE_W-1:0]  next_off;
		bit [WASTE_W-1:0] waste_sum;
		bit [COUNT_W-1:0] wrap_cnt;
		bit [SIZE_W-1:0]  free_max;
		bit [COUNT_W-1:0] req_cnt;
		bit [COUNT_W-1:0] fail_cnt;
		result_beat_t     expected_q[$];
		int               errors;
		int               accepted;
		int               checked;
		int               region_writes;

		task report(string msg);
			$display("MISMATCH t=%0t %s", $time, msg);
			errors++;
		endtask

		function int pending();
			return expected_q.size();
		endfunction

		function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b, bit [63:0] lim);
			if (a > lim || b > lim - a)
				return lim;
			return a + b;
		endfunction

		function void set_region(logic [SIZE_W-1:0] v);
			region = (v > REGION_CAP) ? REGION_CAP : v;
			region_writes++;
		endfunction

		function result_beat_t predict(cmd_beat_t c);
			bit [63:0]    sz;
			bit [63:0]    algn;
			bit [63:0]    aligned;
			bit [63:0]    pad;
			bit [63:0]    tail;
			bit           ok;
			bit           frag;
			result_beat_t r;
			r = '0;
			if (c.action == ACT_RESET) begin
				next_off = '0;
				waste_sum = '0;
				free_max = region;
				r.granted = 1'b1;
			end else begin
				req_cnt = COUNT_W'(sat_add(req_cnt, 1, COUNT_MAX));
				sz = 64'(c.request_size);
				if (region == 0 || sz == 0) begin
					fail_cnt = COUNT_W'(sat_add(fail_cnt, 1, COUNT_MAX));
				end else begin
					algn = (c.alignment == 0) ? 64'd1 : 64'(c.alignment);
					aligned = ((64'(next_off) + algn - 1) / algn) * algn;
					pad = aligned - 64'(next_off);
					ok = 1'b1;
					if (aligned + sz > 64'(region)) begin
						// Wrap to the start; the skipped tail counts as waste.
						aligned = 0;
						if (region > next_off)
							pad += 64'(region - next_off);
						wrap_cnt = COUNT_W'(sat_add(wrap_cnt, 1, COUNT_MAX));
						if (sz > 64'(region)) begin
							fail_cnt = COUNT_W'(sat_add(fail_cnt, 1, COUNT_MAX));
							ok = 1'b0;
						end
					end
					if (ok) begin
						tail = 64'(region) - (aligned + sz);
						waste_sum = WASTE_W'(sat_add(waste_sum, pad, WASTE_MAX));
						if (tail > 64'(free_max))
							free_max = SIZE_W'(tail);
						next_off = SIZE_W'(aligned + sz);
						r.granted = 1'b1;
						r.offset = OFFSET_BITS'(aligned);
					end
				end
			end
			frag = region != 0 &&
				(64'(waste_sum) * 10 > 64'(region) * 3 || wrap_cnt > FRAG_WRAP_LIMIT);
			r.wasted_bytes = waste_sum;
			r.wraps = wrap_cnt;
			r.largest_free = free_max;
			r.alloc_requests = req_cnt;
			r.failed_requests = fail_cnt;
			r.fragmentation_critical = frag;
			r.under_pressure = req_cnt != 0 &&
				(64'(fail_cnt) * 10 > 64'(req_cnt) || frag);
			return r;
		endfunction

		function void note_cmd(cmd_beat_t c);
			expected_q.push_back(predict(c));
			accepted++;
		endfunction

		task cmp_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got %0h, expected %0h",
					checked, name, got, want));
		endtask

		task check(result_beat_t r);
			result_beat_t e;
			if (expected_q.size() == 0) begin
				report("result beat with no command outstanding");
			end else begin
				e = expected_q.pop_front();
				cmp_field("granted", 64'(r.granted), 64'(e.granted));
				cmp_field("offset", 64'(r.offset), 64'(e.offset));
				cmp_field("wasted_bytes", 64'(r.wasted_bytes), 64'(e.wasted_bytes));
				cmp_field("wraps", 64'(r.wraps), 64'(e.wraps));
				cmp_field("largest_free", 64'(r.largest_free), 64'(e.largest_free));
				cmp_field("alloc_requests", 64'(r.alloc_requests), 64'(e.alloc_requests));
				cmp_field("failed_requests", 64'(r.failed_requests),
					64'(e.failed_requests));
				cmp_field("fragmentation_critical", 64'(r.fragmentation_critical),
					64'(e.fragmentation_critical));
				cmp_field("under_pressure", 64'(r.under_pressure), 64'(e.under_pressure));
				checked++;
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	cmd_beat_t          cmd = '0;
	logic               done;
	result_beat_t       result;
	logic               cfg_we = 1'b0;
	logic [SIZE_W-1:0]  cfg_data = '0;
	alloc_scoreboard    sb;

	ring_staging_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The result of an earlier command is checked before a command taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check(result);
			if (start && !busy)
				sb.note_cmd(cmd);
			if (cfg_we)
				sb.set_region(cfg_data);
		end
	end

	// Presents one command after a random idle stretch and returns at the edge that takes it.
	task automatic send_cmd(cmd_beat_t b, int idle_pct);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= b;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic dir_cmd(logic act, logic [SIZE_W-1:0] sz, logic [ALIGN_W-1:0] algn);
		cmd_beat_t b;
		b.action = act;
		b.request_size = sz;
		b.alignment = algn;
		send_cmd(b, 0);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0 || busy)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	// The region register is only written once every outstanding beat has come back.
	task automatic write_region(logic [SIZE_W-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic cmd_beat_t rand_cmd(bit [SIZE_W-1:0] region);
		cmd_beat_t b;
		int        k;
		int        span;
		b.action = ($urandom_range(99) < 8) ? ACT_RESET : ACT_ALLOC;
		k = $urandom_range(99);
		span = (region / 6 > 1) ? int'(region / 6) : 1;
		if (k < 5)
			b.request_size = '0;
		else if (k < 10)
			b.request_size = SIZE_W'($urandom);
		else if (k < 15)
			b.request_size = SIZE_W'(region + $urandom_range(1, 16));
		else if (k < 25)
			b.request_size = (region > 4) ? SIZE_W'(region - $urandom_range(0, 4)) :
				SIZE_W'($urandom_range(1, 4));
		else
			b.request_size = SIZE_W'($urandom_range(1, span));
		k = $urandom_range(99);
		if (k < 60)
			b.alignment = ALIGN_W'(1) << $urandom_range(0, 16);
		else if (k < 75)
			b.alignment = ALIGN_W'($urandom_range(1, 16));
		else if (k < 80)
			b.alignment = '0;
		else
			b.alignment = ALIGN_W'($urandom);
		return b;
	endfunction

	initial begin
		int               idle_pct;
		int               n_items;
		logic [SIZE_W-1:0] rv;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No region yet: allocate fails, reset still grants.
		dir_cmd(ACT_ALLOC, 16, 4);
		dir_cmd(ACT_RESET, 0, 1);
		write_region(1000);
		dir_cmd(ACT_ALLOC, 0, 8);
		dir_cmd(ACT_ALLOC, 100, 0);
		dir_cmd(ACT_ALLOC, 50, 64);
		dir_cmd(ACT_ALLOC, 300, '1);
		dir_cmd(ACT_ALLOC, 1000, 1);
		dir_cmd(ACT_ALLOC, 1001, 1);
		dir_cmd(ACT_ALLOC, '1, 17'h10000);
		dir_cmd(ACT_ALLOC, 900, 8);
		dir_cmd(ACT_RESET, '1, '1);
		dir_cmd(ACT_ALLOC, 800, 1);
		// Shrinking the region below the current offset leaves no tail to waste.
		write_region(300);
		dir_cmd(ACT_ALLOC, 100, 1);
		write_region('1);
		dir_cmd(ACT_RESET, 0, 1);
		dir_cmd(ACT_ALLOC, REGION_CAP, 17'h10000);
		dir_cmd(ACT_ALLOC, 1, 1);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: rv = SIZE_W'($urandom_range(1, 256));
				1: rv = 1;
				2: rv = 0;
				3: rv = REGION_CAP;
				4: rv = '1;
				5: rv = SIZE_W'($urandom_range(1, 65536));
				6: rv = SIZE_W'($urandom);
				default: rv = SIZE_W'($urandom_range(2, 64));
			endcase
			write_region(rv);
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 66;
				default: idle_pct = 17;
			endcase
			n_items = (rv == 0) ? 20 : 64;
			repeat (n_items)
				send_cmd(rand_cmd(sb.region), idle_pct);
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected result beats never arrived", sb.pending()));
		$display("Checked %0d of %0d commands across %0d region settings,", sb.checked,
			sb.accepted, sb.region_writes);
		$display("with sender idle patterns of 0, 17 and 66 percent; %0d mismatches.",
			sb.errors);
		if (sb.errors == 0)
			$display("[ring_staging_allocator_unit] OK");
		else
			$display("[ring_staging_allocator_unit] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout: the run did not finish in time.");
		$display("[ring_staging_allocator_unit] ERROR");
		$finish;
	end

endmodule

/* ring_staging_allocator_unit.f */
rtl/rsa_pkg.sv
rtl/rsa_rem_unit.sv
rtl/rsa_health.sv
rtl/ring_staging_allocator_unit.sv
tb/ring_staging_allocator_unit_tb.sv
